// ----- sv/mtg_pkg.sv -----
// Shared constants, command/status types and the tempering function of the twister core.
`default_nettype none
package mtg_pkg;

    localparam int TABLE_WORDS_DEF   = 624;
    localparam int MIDDLE_OFFSET_DEF = 397;

    localparam logic [31:0] SEED_RESET   = 32'd5489;
    localparam logic [31:0] INIT_FACTOR  = 32'd1812433253;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
    localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;

    localparam int INIT_SHIFT = 30;
    localparam int TEMPER_U   = 11;
    localparam int TEMPER_S   = 7;
    localparam int TEMPER_T   = 15;
    localparam int TEMPER_L   = 18;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic fill_load;   // load seed word, restart the fill index
        logic fill_step;   // write one seeded word, advance the recurrence
        logic tw_rd_nxt;   // read the next and middle words
        logic tw_rd_cur;   // hold low bits of the next word, read the current word
        logic tw_write;    // write one twisted word, advance the index
        logic out_load;    // temper the read word into the output register
    } mtg_cmd_t;

    typedef struct packed {
        logic idx_last;    // table index sits on the last word
        logic pos_end;     // draw position is past the table
        logic out_free;    // output register can take a new word
    } mtg_status_t;

    function automatic logic [31:0] mtg_temper(input logic [31:0] y);
        logic [31:0] t;
        t = y ^ (y >> TEMPER_U);
        t = t ^ ((t << TEMPER_S) & TEMPER_B);
        t = t ^ ((t << TEMPER_T) & TEMPER_C);
        t = t ^ (t >> TEMPER_L);
        return t;
    endfunction

endpackage
`default_nettype wire

// ----- sv/mtg_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
`default_nettype none
module mtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr_a,
    output logic      [WIDTH-1:0] rd_data_a,
    input  wire logic [AW-1:0]    rd_addr_b,
    output logic      [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_a_reg <= mem_reg[rd_addr_a];
        rd_data_b_reg <= mem_reg[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule
`default_nettype wire

// ----- sv/mtg_ctrl.sv -----
// Controller state machine: sequences seeding, the table twist and draws.
`default_nettype none
module mtg_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_draw_request,
    input  wire mtg_pkg::mtg_status_t status,
    output mtg_pkg::mtg_cmd_t        cmd
);
    import mtg_pkg::*;

    typedef enum logic [6:0] {
        ST_FILL       = 7'b0000001,
        ST_IDLE       = 7'b0000010,
        ST_TW_RD_NXT  = 7'b0000100,
        ST_TW_RD_CUR  = 7'b0001000,
        ST_TW_WR      = 7'b0010000,
        ST_DR_RD      = 7'b0100000,
        ST_DR_OUT     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (status.idx_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_draw_request) begin
                    state_next = status.pos_end ? ST_TW_RD_NXT : ST_DR_OUT;
                end
            end
            ST_TW_RD_NXT: begin
                cmd.tw_rd_nxt = 1'b1;
                state_next    = ST_TW_RD_CUR;
            end
            ST_TW_RD_CUR: begin
                cmd.tw_rd_cur = 1'b1;
                state_next    = ST_TW_WR;
            end
            ST_TW_WR: begin
                cmd.tw_write = 1'b1;
                state_next   = status.idx_last ? ST_DR_RD : ST_TW_RD_NXT;
            end
            ST_DR_RD: begin
                state_next = ST_DR_OUT;
            end
            ST_DR_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
        // a seed write restarts the fill from any state; take no item with it
        if (cfg_wr_en) begin
            cmd           = '0;
            cmd.fill_load = 1'b1;
            s_ready       = 1'b0;
            state_next    = ST_FILL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/mtg_datapath.sv -----
// Datapath: table RAM, seeding recurrence, twist step, draw position and output register.
`default_nettype none
module mtg_datapath #(
    parameter int TABLE_WORDS   = mtg_pkg::TABLE_WORDS_DEF,
    parameter int MIDDLE_OFFSET = mtg_pkg::MIDDLE_OFFSET_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mtg_pkg::mtg_cmd_t cmd,
    output mtg_pkg::mtg_status_t   status,
    input  wire logic [31:0]       cfg_wr_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [31:0]       m_random_word
);
    import mtg_pkg::*;

    localparam int AW   = $clog2(TABLE_WORDS);
    localparam int PW   = $clog2(TABLE_WORDS + 1);
    localparam int LAST = TABLE_WORDS - 1;
    localparam int WRAP = TABLE_WORDS - MIDDLE_OFFSET;

    logic [AW-1:0] idx_reg;
    logic [PW-1:0] pos_reg;
    logic [31:0]   fill_word_reg;
    logic [30:0]   nxt_low_reg;
    logic [31:0]   word_reg;
    logic          valid_reg;

    logic          idx_last;
    logic [AW-1:0] idx_nxt;
    logic [AW-1:0] idx_mid;
    logic          pos_end;
    logic [31:0]   fill_mix;
    logic [31:0]   fill_next;
    logic [31:0]   tw_x;
    logic [31:0]   tw_xa;
    logic [31:0]   tw_word;
    logic          ram_wr_en;
    logic [31:0]   ram_wr_data;
    logic [AW-1:0] ram_rd_addr_a;
    logic [31:0]   ram_rd_data_a;
    logic [31:0]   ram_rd_data_b;

    assign idx_last = (idx_reg == AW'(LAST));
    assign idx_nxt  = idx_last ? '0 : idx_reg + AW'(1);
    assign idx_mid  = (idx_reg < AW'(WRAP)) ? idx_reg + AW'(MIDDLE_OFFSET)
                                            : idx_reg - AW'(WRAP);
    assign pos_end  = (pos_reg == PW'(TABLE_WORDS));

    assign fill_mix  = fill_word_reg ^ (fill_word_reg >> INIT_SHIFT);
    assign fill_next = INIT_FACTOR * fill_mix + 32'(idx_reg) + 32'd1;

    assign tw_x    = {ram_rd_data_a[31], nxt_low_reg};
    assign tw_xa   = {1'b0, tw_x[31:1]} ^ (tw_x[0] ? TWIST_MATRIX : 32'd0);
    assign tw_word = ram_rd_data_b ^ tw_xa;

    assign ram_wr_en   = cmd.fill_step | cmd.tw_write;
    assign ram_wr_data = cmd.fill_step ? fill_word_reg : tw_word;

    always_comb begin
        if (cmd.tw_rd_nxt) begin
            ram_rd_addr_a = idx_nxt;
        end else if (cmd.tw_rd_cur) begin
            ram_rd_addr_a = idx_reg;
        end else begin
            ram_rd_addr_a = pos_end ? '0 : pos_reg[AW-1:0];
        end
    end

    mtg_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_WORDS)
    ) u_mtg_ram (
        .aclk      (aclk),
        .wr_en     (ram_wr_en),
        .wr_addr   (idx_reg),
        .wr_data   (ram_wr_data),
        .rd_addr_a (ram_rd_addr_a),
        .rd_data_a (ram_rd_data_a),
        .rd_addr_b (idx_mid),
        .rd_data_b (ram_rd_data_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            pos_reg       <= PW'(TABLE_WORDS);
            fill_word_reg <= SEED_RESET;
            valid_reg     <= 1'b0;
        end else begin
            if (cmd.fill_load) begin
                fill_word_reg <= cfg_wr_data;
                idx_reg       <= '0;
                pos_reg       <= PW'(TABLE_WORDS);
            end else if (cmd.fill_step) begin
                fill_word_reg <= fill_next;
                idx_reg       <= idx_nxt;
            end else if (cmd.tw_write) begin
                idx_reg <= idx_nxt;
                if (idx_last) begin
                    pos_reg <= '0;
                end
            end else if (cmd.out_load) begin
                pos_reg <= pos_reg + PW'(1);
            end
            if (cmd.out_load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tw_rd_cur) begin
            nxt_low_reg <= ram_rd_data_a[30:0];
        end
        if (cmd.out_load) begin
            word_reg <= mtg_temper(ram_rd_data_a);
        end
    end

    assign status.idx_last = idx_last;
    assign status.pos_end  = pos_end;
    assign status.out_free = ~valid_reg | m_ready;

    assign m_valid       = valid_reg;
    assign m_random_word = word_reg;

endmodule
`default_nettype wire

// ----- sv/mersenne_twister_generator_core.sv -----
// Top level of the 32-bit Mersenne Twister generator core.
// Draw: an item is accepted in the idle state, the table RAM read is registered, and the word is
//   tempered into the output register once it is free; no new item is taken before that load.
// The draw that finds the table used up first twists all words, each word in turn by
//   read next and middle, read current, write; then it re-reads the drawn word.
// Reset and every seed write refill the table, one word per cycle, with s_ready low.
// Reset loads seed 5489; a seed write reseeds at once.
`default_nettype none
module mersenne_twister_generator_core #(
    parameter int TABLE_WORDS   = mtg_pkg::TABLE_WORDS_DEF,
    parameter int MIDDLE_OFFSET = mtg_pkg::MIDDLE_OFFSET_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // seed register write port
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    // draw request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_draw_request,
    // random word channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_random_word
);
    import mtg_pkg::*;

    // Commands flow down from the controller; the datapath answers with
    // index, position and output-register status.
    mtg_cmd_t    cmd;
    mtg_status_t status;

    // The controller owns sequencing: fill after reset or a seed write,
    // the three-phase twist walk, and the draw read/load handshake.
    // An item with draw_request low is taken and dropped without a result.
    mtg_ctrl u_mtg_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_draw_request (s_draw_request),
        .status         (status),
        .cmd            (cmd)
    );

    // The datapath holds the table RAM, the seeding multiply (one per
    // cycle, registered), the twist step and the output register that
    // parts the result side from the request side.
    mtg_datapath #(
        .TABLE_WORDS   (TABLE_WORDS),
        .MIDDLE_OFFSET (MIDDLE_OFFSET)
    ) u_mtg_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_data   (cfg_wr_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_random_word (m_random_word)
    );

endmodule
`default_nettype wire

// ----- sv/mtg_checker.sv -----
// Port-level checker for the twister core, bound to the top level.
`default_nettype none
module mtg_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_wr_en,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_draw_request,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_random_word
);

    // a stalled result holds its word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_random_word))
        else $error("stalled random word changed or dropped");

    // reset starts the table fill, so no item is taken right after it
    a_reset_fill: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high right after reset");

    // a seed write restarts the fill
    a_seed_fill: assert property (@(posedge aclk)
        cfg_wr_en |=> !s_ready)
        else $error("s_ready high right after a seed write");

    // one draw at a time: an accepted draw blocks the next cycle
    a_one_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_draw_request |=> !s_ready)
        else $error("second draw accepted back to back");

endmodule

bind mersenne_twister_generator_core mtg_checker u_mtg_checker (.*);
`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the Mersenne Twister generator core: seeded draws against a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mtg_pkg::*;

    localparam int N_WORDS      = TABLE_WORDS_DEF;
    localparam int MID_OFS      = MIDDLE_OFFSET_DEF;
    // The worst case has long gaps on both sides, a twist per 624 words and a refill
    // per seed write; the limit keeps a wide margin over it.
    localparam int CYCLE_LIMIT  = 1_000_000;
    // Idle time after draining, with slack for a word still in the core.
    localparam int DRAIN_CYCLES = 8;
    localparam int RESET_CYCLES = 9;
    localparam int ZERO_PCT     = 4;

    // Predicts the tempered words of the twister and holds the ones still due.
    class mt_word_board;
        bit [31:0]   mt_state [N_WORDS];
        int unsigned draw_pos;
        logic [31:0] pending_words [$];
        int unsigned mismatches;
        int unsigned words_seen;
        int unsigned twists;
        int unsigned empty_requests;

        function new();
            mismatches     = 0;
            words_seen     = 0;
            twists         = 0;
            empty_requests = 0;
            reseed(SEED_RESET);
        endfunction

        function void reseed(bit [31:0] seed);
            bit [31:0] prev;
            int        k;
            mt_state[0] = seed;
            for (k = 1; k < N_WORDS; k++) begin
                prev        = mt_state[k-1];
                mt_state[k] = INIT_FACTOR * (prev ^ (prev >> INIT_SHIFT)) + 32'(k);
            end
            draw_pos = N_WORDS;
        endfunction

        function void twist();
            bit [31:0] x;
            bit [31:0] xa;
            int        k;
            int        nxt;
            int        mid;
            for (k = 0; k < N_WORDS; k++) begin
                nxt = (k + 1) % N_WORDS;
                mid = (k + MID_OFS) % N_WORDS;
                x   = {mt_state[k][31], mt_state[nxt][30:0]};
                xa  = x >> 1;
                if (x[0])
                    xa = xa ^ TWIST_MATRIX;
                mt_state[k] = mt_state[mid] ^ xa;
            end
            draw_pos = 0;
            twists++;
        endfunction

        function bit [31:0] temper(bit [31:0] y);
            bit [31:0] t;
            t = y ^ (y >> 11);
            t = t ^ ((t << 7) & TEMPER_B);
            t = t ^ ((t << 15) & TEMPER_C);
            t = t ^ (t >> 18);
            return t;
        endfunction

        function void note_draw(bit req);
            if (!req) begin
                empty_requests++;
                return;
            end
            if (draw_pos >= N_WORDS)
                twist();
            pending_words.push_back(temper(mt_state[draw_pos]));
            draw_pos++;
        endfunction

        function void check_word(logic [31:0] got);
            logic [31:0] want;
            if (pending_words.size() == 0) begin
                $display("%t: random_word %h arrived with no word due", $time, got);
                mismatches++;
                return;
            end
            want = pending_words.pop_front();
            words_seen++;
            if (got !== want) begin
                $display("%t: random_word expected %h actual %h", $time, want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [31:0] cfg_wr_data    = '0;
    logic        s_valid        = 1'b0;
    logic        s_draw_request = 1'b0;
    logic        m_ready        = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire  [31:0] m_random_word;

    mt_word_board board;
    bit           no_idle;
    int unsigned  seeds_used;

    mersenne_twister_generator_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_draw_request (s_draw_request),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_random_word  (m_random_word)
    );

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Hard stop: a hung handshake or a lost word ends here.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("FAILURE");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: stall m_ready at random, changing it at the falling edge only.
    initial begin : word_sink
        int stall;
        stall = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_ready = 1'b0;
                stall--;
            end else begin
                m_ready = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    // Sample the result channel at the rising edge, before the core updates.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_word(m_random_word);
    end

    // Send one request item. Starts and ends on a falling edge; valid holds until accepted.
    task automatic send_draw(input bit req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_draw_request = req;
        do
            @(posedge aclk);
        while (!s_ready);
        board.note_draw(req);
        @(negedge aclk);
    endtask

    // Hold the request side until every due word has come out.
    task automatic drain_words();
        s_valid = 1'b0;
        while (board.pending_words.size() != 0)
            @(negedge aclk);
    endtask

    // Write the seed only with the core idle: drain, let the pipeline settle, then write.
    task automatic write_seed(input logic [31:0] seed);
        drain_words();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = seed;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        board.reseed(seed);
        seeds_used++;
    endtask

    // Random phase: count real draws, with a few empty requests mixed in.
    task automatic run_draws(input int count);
        int drawn;
        int sent;
        bit req;
        drawn = 0;
        sent  = 0;
        while (drawn < count) begin
            // Switch between idling and back-to-back stretches.
            if (sent % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            // Pause the sender until the core is empty, once per phase and now and then.
            if (drawn == count / 2 || $urandom_range(0, 299) == 0)
                drain_words();
            req = ($urandom_range(0, 99) >= ZERO_PCT);
            send_draw(req);
            sent++;
            if (req)
                drawn++;
        end
        s_valid = 1'b0;
    endtask

    initial begin : stimulus
        board      = new();
        no_idle    = 1'b0;
        seeds_used = 1;

        // Hold reset, then release on a falling edge.
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        // Reset seed: the first draw twists the freshly filled table;
        // requests with the request bit low must produce nothing.
        send_draw(1'b1);
        send_draw(1'b0);
        send_draw(1'b1);
        send_draw(1'b1);
        send_draw(1'b0);
        send_draw(1'b1);
        s_valid = 1'b0;

        // Lowest seed, then reseed with the highest in the middle of a table.
        write_seed(32'h0000_0000);
        send_draw(1'b1);
        send_draw(1'b1);
        send_draw(1'b0);
        send_draw(1'b1);
        send_draw(1'b1);
        s_valid = 1'b0;
        write_seed(32'hFFFF_FFFF);
        send_draw(1'b1);
        send_draw(1'b1);
        send_draw(1'b1);
        send_draw(1'b1);
        s_valid = 1'b0;

        // Random seeds; the long phase crosses three twists, the others reseed mid-table.
        write_seed($urandom);
        run_draws(1300);
        write_seed(SEED_RESET);
        run_draws(200);
        write_seed($urandom);
        run_draws(237);

        // Drain and give the core time to show any stray word.
        drain_words();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Checked %0d random words and %0d empty requests across %0d seeds,",
                 board.words_seen, board.empty_requests, seeds_used);
        $display("with %0d table twists and random stalls on both channels.", board.twists);
        if (board.mismatches == 0 && board.pending_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
